// ===== hdl/hrgbw_pkg.sv =====
// Shared codes, microcode word layout and control program of the HSV to RGBW LED drive.
package hrgbw_pkg;

	// Request kinds carried in the low bits of the input tuser.
	localparam logic [1:0] REQ_HSV  = 2'd0;
	localparam logic [1:0] REQ_CHAN = 2'd1;
	localparam logic [1:0] REQ_BRI  = 2'd2;

	// Channel selector codes.
	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;
	localparam logic [1:0] CH_WHITE = 2'd3;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_RED_LIMIT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GREEN_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE_LIMIT  = 2'd2;

	// Input tuser: req_type then channel_sel.
	localparam int TUSER_W = 4;

	// Brightness is unsigned Q8.
	localparam int BRI_W = 9;
	localparam logic [BRI_W-1:0] BRI_FULL = 9'd256;
	localparam int BRI_SHIFT = 8;

	// Microcode step counter.
	localparam int UPC_W = 4;
	localparam logic [UPC_W-1:0] UPC_HSV  = 4'd0;
	localparam logic [UPC_W-1:0] UPC_DUTY = 4'd6;
	localparam logic [UPC_W-1:0] UPC_LAST = 4'd14;

	typedef enum logic [2:0] {A_ZERO, A_F, A_MS, A_DFS, A_DFSC, A_LVL, A_PROD} asel_t;
	typedef enum logic [2:0] {B_ZERO, B_S, B_V, B_LIM, B_BRI} bsel_t;
	typedef enum logic [2:0] {W_NONE, W_FS, W_P, W_Q, W_T, W_HSV, W_DUTY, W_WDUTY} wsel_t;
	typedef enum logic [1:0] {DSH_NONE, DSH_HUE, DSH_BRI} dsh_t;
	typedef enum logic {SEQ_NEXT, SEQ_END} seq_t;

	typedef struct packed {
		asel_t      asel;  // multiplier operand A
		bsel_t      bsel;  // multiplier operand B
		logic [1:0] ich;   // channel of the issued product
		wsel_t      wsel;  // destination of the previous product
		logic [1:0] wch;   // channel of the written duty
		dsh_t       dsh;   // scaling ahead of the divide by full scale
		seq_t       seq;
	} uop_t;

	function automatic uop_t mk_uop(asel_t a, bsel_t b, logic [1:0] ich, wsel_t w,
		logic [1:0] wch, dsh_t d, seq_t s);
		uop_t u;
		u.asel = a;
		u.bsel = b;
		u.ich  = ich;
		u.wsel = w;
		u.wch  = wch;
		u.dsh  = d;
		u.seq  = s;
		return u;
	endfunction

	// Control program. HSV runs from UPC_HSV and falls into the duty pass;
	// every other request enters at UPC_DUTY.
	function automatic uop_t uop_rom(logic [UPC_W-1:0] pc);
		uop_t u;
		case (pc)
			4'd0:  u = mk_uop(A_F,    B_S,    CH_RED,   W_NONE,  CH_RED,   DSH_NONE, SEQ_NEXT);
			4'd1:  u = mk_uop(A_MS,   B_V,    CH_RED,   W_FS,    CH_RED,   DSH_NONE, SEQ_NEXT);
			4'd2:  u = mk_uop(A_DFS,  B_V,    CH_RED,   W_P,     CH_RED,   DSH_NONE, SEQ_NEXT);
			4'd3:  u = mk_uop(A_DFSC, B_V,    CH_RED,   W_Q,     CH_RED,   DSH_HUE,  SEQ_NEXT);
			4'd4:  u = mk_uop(A_ZERO, B_ZERO, CH_RED,   W_T,     CH_RED,   DSH_HUE,  SEQ_NEXT);
			4'd5:  u = mk_uop(A_ZERO, B_ZERO, CH_RED,   W_HSV,   CH_RED,   DSH_NONE, SEQ_NEXT);
			4'd6:  u = mk_uop(A_LVL,  B_LIM,  CH_RED,   W_NONE,  CH_RED,   DSH_NONE, SEQ_NEXT);
			4'd7:  u = mk_uop(A_PROD, B_BRI,  CH_RED,   W_NONE,  CH_RED,   DSH_NONE, SEQ_NEXT);
			4'd8:  u = mk_uop(A_LVL,  B_LIM,  CH_GREEN, W_DUTY,  CH_RED,   DSH_BRI,  SEQ_NEXT);
			4'd9:  u = mk_uop(A_PROD, B_BRI,  CH_GREEN, W_NONE,  CH_RED,   DSH_NONE, SEQ_NEXT);
			4'd10: u = mk_uop(A_LVL,  B_LIM,  CH_BLUE,  W_DUTY,  CH_GREEN, DSH_BRI,  SEQ_NEXT);
			4'd11: u = mk_uop(A_PROD, B_BRI,  CH_BLUE,  W_NONE,  CH_RED,   DSH_NONE, SEQ_NEXT);
			4'd12: u = mk_uop(A_LVL,  B_BRI,  CH_WHITE, W_DUTY,  CH_BLUE,  DSH_BRI,  SEQ_NEXT);
			4'd13: u = mk_uop(A_ZERO, B_ZERO, CH_RED,   W_WDUTY, CH_WHITE, DSH_NONE, SEQ_NEXT);
			default: u = mk_uop(A_ZERO, B_ZERO, CH_RED, W_NONE,  CH_RED,   DSH_NONE, SEQ_END);
		endcase
		return u;
	endfunction

endpackage

// ===== hdl/hsv_to_rgbw_led_drive.sv =====
// HSV to RGBW LED drive: microcoded sequencer around one shared multiplier.
//
// Converts a hue/saturation/value colour into red, green and blue levels with the
// six-sector formula, sets one channel level (white included) directly, or sets a
// global Q8 brightness that saturates at 256. After every input beat it returns one
// output beat with the four PWM duties and the stored state. Colour duty is
// level*limit*brightness/(full*256), white duty is level*brightness/256, both
// truncated. Channel, brightness and unused requests run the duty pass of the control
// program only, an HSV request runs all of it, and the last step holds while the output
// register waits on m_tready. Program length is set by the single multiplier: HSV needs
// four products, each colour duty two and the white duty one, issued one per step of
// the control program. The block takes one item at a time; s_tready is low while the
// program runs, and a result waiting in the output register does not block the next
// accept. Configuration writes are always ready and must happen while the block is
// idle; indexes beyond the blue limit are dropped. Divides by full scale use one
// add-and-compare correction on the high and low halves of the product.
module hsv_to_rgbw_led_drive #(
	parameter int LEVEL_BITS = 8,
	parameter int HUE_BITS = 16,
	localparam int IN_TW = ((HUE_BITS + 3 * LEVEL_BITS + 9 + 7) / 8) * 8,
	localparam int OUT_TW = ((8 * LEVEL_BITS + 9 + 7) / 8) * 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// hue, saturation, intensity, channel_level, brightness_in (lowest first)
	input  logic [IN_TW-1:0]                    s_tdata,
	// req_type, channel_sel (lowest first)
	input  logic [hrgbw_pkg::TUSER_W-1:0]       s_tuser,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// red_duty, green_duty, blue_duty, white_duty, red_level, green_level,
	// blue_level, white_level, brightness_now (lowest first)
	output logic [OUT_TW-1:0]                   m_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [hrgbw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [LEVEL_BITS-1:0]               cfg_data
);
	import hrgbw_pkg::*;

	localparam int L = LEVEL_BITS;
	localparam int H = HUE_BITS;
	localparam int WA = (L + H > 2 * L) ? L + H : 2 * L;
	localparam int WB = (L > BRI_W) ? L : BRI_W;
	localparam int WP = WA + WB;
	localparam logic [L-1:0] LMAX = {L{1'b1}};
	localparam logic [L+H-1:0] D_FULL = {LMAX, {H{1'b0}}};

	// Input fields
	logic [H-1:0]     in_hue;
	logic [L-1:0]     in_sat;
	logic [L-1:0]     in_int;
	logic [L-1:0]     in_lvl;
	logic [BRI_W-1:0] in_bri;
	logic [1:0]       in_req;
	logic [1:0]       in_sel;

	assign in_hue = s_tdata[H-1:0];
	assign in_sat = s_tdata[H+L-1:H];
	assign in_int = s_tdata[H+2*L-1:H+L];
	assign in_lvl = s_tdata[H+3*L-1:H+2*L];
	assign in_bri = s_tdata[H+3*L+BRI_W-1:H+3*L];
	assign in_req = s_tuser[1:0];
	assign in_sel = s_tuser[3:2];

	// Control and architectural state
	logic             busy_q;
	logic [UPC_W-1:0] pc_q;
	logic             m_tvalid_q;
	logic [L-1:0]     lim_q [3];
	logic [L-1:0]     lvl_q [4];
	logic [BRI_W-1:0] bri_q;

	// Datapath registers
	logic [H-1:0]     h_q;
	logic [L-1:0]     s_q;
	logic [L-1:0]     v_q;
	logic [L+H-1:0]   fs_q;
	logic [L-1:0]     p_q;
	logic [L-1:0]     q_q;
	logic [L-1:0]     t_q;
	logic [WP-1:0]    prod_q;
	logic [L-1:0]     duty_q [4];
	logic [OUT_TW-1:0] m_tdata_q;

	uop_t             uop;
	logic             accept;
	logic             end_go;
	logic [H+2:0]     h6;
	logic [2:0]       sector;
	logic [L-1:0]     ms;
	logic [L-1:0]     lim_sel;
	logic [WA-1:0]    mul_a;
	logic [WB-1:0]    mul_b;
	logic [2*L-1:0]   div_y;
	logic [L:0]       div_sum;
	logic [L:0]       div_quo;
	logic [L-1:0]     quo;
	logic [BRI_W-1:0] bri_sat;

	assign uop       = uop_rom(pc_q);
	assign accept    = s_tvalid && s_tready;
	assign s_tready  = !busy_q;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	// Load the result only when the output register is free or being emptied.
	assign end_go    = busy_q && (uop.seq == SEQ_END) && (!m_tvalid_q || m_tready);

	// Sector and fraction of the hue: hue*6 split at the turn boundary.
	assign h6     = {1'b0, h_q, 2'b00} + {2'b00, h_q, 1'b0};
	assign sector = h6[H+2:H];
	assign ms     = LMAX - s_q;

	assign bri_sat = (in_bri > BRI_FULL) ? BRI_FULL : in_bri;

	always_comb begin
		case (uop.ich)
			CH_RED:   lim_sel = lim_q[0];
			CH_GREEN: lim_sel = lim_q[1];
			CH_BLUE:  lim_sel = lim_q[2];
			default:  lim_sel = LMAX;
		endcase
	end

	// Operand select for the shared multiplier
	always_comb begin
		case (uop.asel)
			A_F:     mul_a = WA'(h6[H-1:0]);
			A_MS:    mul_a = WA'(ms);
			A_DFS:   mul_a = WA'(D_FULL - fs_q);
			A_DFSC:  mul_a = WA'(fs_q + {ms, {H{1'b0}}});
			A_LVL:   mul_a = WA'(lvl_q[uop.ich]);
			A_PROD:  mul_a = WA'(prod_q[2*L-1:0]);
			default: mul_a = '0;
		endcase
		case (uop.bsel)
			B_S:     mul_b = WB'(s_q);
			B_V:     mul_b = WB'(v_q);
			B_LIM:   mul_b = WB'(lim_sel);
			B_BRI:   mul_b = WB'(bri_q);
			default: mul_b = '0;
		endcase
	end

	// Divide by full scale: y = a*2^L + b gives a + (a + b >= full).
	always_comb begin
		case (uop.dsh)
			DSH_HUE: div_y = prod_q[H+2*L-1:H];
			DSH_BRI: div_y = prod_q[BRI_SHIFT+2*L-1:BRI_SHIFT];
			default: div_y = prod_q[2*L-1:0];
		endcase
		div_sum = {1'b0, div_y[2*L-1:L]} + {1'b0, div_y[L-1:0]};
		div_quo = {1'b0, div_y[2*L-1:L]} + {{L{1'b0}}, (div_sum >= {1'b0, LMAX})};
		quo     = div_quo[L-1:0];
	end

	// Sequencer, configuration and stored levels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			pc_q       <= UPC_DUTY;
			m_tvalid_q <= 1'b0;
			lim_q[0]   <= LMAX;
			lim_q[1]   <= LMAX;
			lim_q[2]   <= LMAX;
			lvl_q[0]   <= '0;
			lvl_q[1]   <= '0;
			lvl_q[2]   <= '0;
			lvl_q[3]   <= '0;
			bri_q      <= BRI_FULL;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_RED_LIMIT:   lim_q[0] <= cfg_data;
					REG_GREEN_LIMIT: lim_q[1] <= cfg_data;
					REG_BLUE_LIMIT:  lim_q[2] <= cfg_data;
					default: ;
				endcase
			end

			// Present a new result at program end, else drop the one just taken.
			if (end_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			if (accept) begin
				busy_q <= 1'b1;
				pc_q   <= (in_req == REQ_HSV) ? UPC_HSV : UPC_DUTY;
				if (in_req == REQ_CHAN) begin
					lvl_q[in_sel] <= in_lvl;
				end
				if (in_req == REQ_BRI) begin
					bri_q <= bri_sat;
				end
			end else if (busy_q) begin
				if (uop.wsel == W_HSV) begin
					case (sector)
						3'd0: begin
							lvl_q[0] <= v_q; lvl_q[1] <= t_q; lvl_q[2] <= p_q;
						end
						3'd1: begin
							lvl_q[0] <= q_q; lvl_q[1] <= v_q; lvl_q[2] <= p_q;
						end
						3'd2: begin
							lvl_q[0] <= p_q; lvl_q[1] <= v_q; lvl_q[2] <= t_q;
						end
						3'd3: begin
							lvl_q[0] <= p_q; lvl_q[1] <= q_q; lvl_q[2] <= v_q;
						end
						3'd4: begin
							lvl_q[0] <= t_q; lvl_q[1] <= p_q; lvl_q[2] <= v_q;
						end
						default: begin
							lvl_q[0] <= v_q; lvl_q[1] <= p_q; lvl_q[2] <= q_q;
						end
					endcase
				end
				if (uop.seq == SEQ_END) begin
					// hold at the last step until the output register frees up
					if (end_go) begin
						busy_q <= 1'b0;
					end
				end else begin
					pc_q <= pc_q + 1'b1;
				end
			end
		end
	end

	// Payload and working registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (accept) begin
			h_q <= in_hue;
			s_q <= in_sat;
			v_q <= in_int;
		end
		if (busy_q) begin
			case (uop.wsel)
				W_FS:    fs_q <= prod_q[L+H-1:0];
				W_P:     p_q  <= quo;
				W_Q:     q_q  <= quo;
				W_T:     t_q  <= quo;
				W_DUTY:  duty_q[uop.wch] <= quo;
				W_WDUTY: duty_q[3] <= prod_q[BRI_SHIFT+L-1:BRI_SHIFT];
				default: ;
			endcase
		end
		if (end_go) begin
			m_tdata_q <= OUT_TW'({bri_q, lvl_q[3], lvl_q[2], lvl_q[1], lvl_q[0],
				duty_q[3], duty_q[2], duty_q[1], duty_q[0]});
		end
	end

	// Stored brightness never exceeds full scale.
	a_bri_range: assert property (@(posedge clk) disable iff (!arst_n)
		bri_q <= BRI_FULL)
		else $error("brightness above full scale");

	// The step counter stays inside the program while it runs.
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> pc_q <= UPC_LAST)
		else $error("microcode step out of range");

	// Finishing the program presents a result and frees the input side.
	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		end_go |=> (m_tvalid && s_tready))
		else $error("program end did not load the result");

	// An accepted beat always starts the program.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy_q && (pc_q == UPC_HSV || pc_q == UPC_DUTY)))
		else $error("accept did not start the program");

endmodule
